// File: rtl/radix_integer_text_parser_top_defines.svh
// Assertion macros shared by the radix integer text parser checkers.
// No dependencies; the including scope supplies clock and reset.
`ifndef RADIX_INTEGER_TEXT_PARSER_TOP_DEFINES_SVH
`define RADIX_INTEGER_TEXT_PARSER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define RITP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RITP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ritp_pkg.sv
// Shared types, constants and helper functions for the radix integer text parser.
// No dependencies.
package ritp_pkg;

   // Default sizes handed to the top level
   localparam int VALUE_BITS_DEF = 64;
   localparam int INDEX_BITS_DEF = 16;

   // Port widths
   localparam int CH_BITS       = 8;
   localparam int RADIX_BITS    = 6;
   localparam int VALUE_OUT     = 64;
   localparam int END_OUT       = 16;
   localparam int STATUS_BITS   = 2;
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = VALUE_OUT + END_OUT;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register map
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_DEFAULT = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;

   // Character codes
   localparam logic [CH_BITS-1:0] CH_SPACE = 8'd32;
   localparam logic [CH_BITS-1:0] CH_TAB   = 8'd9;
   localparam logic [CH_BITS-1:0] CH_CR    = 8'd13;
   localparam logic [CH_BITS-1:0] CH_PLUS  = 8'd43;
   localparam logic [CH_BITS-1:0] CH_MINUS = 8'd45;
   localparam logic [CH_BITS-1:0] CH_ZERO  = 8'd48;
   localparam logic [CH_BITS-1:0] CH_NINE  = 8'd57;
   localparam logic [CH_BITS-1:0] CH_UC_A  = 8'd65;
   localparam logic [CH_BITS-1:0] CH_UC_Z  = 8'd90;
   localparam logic [CH_BITS-1:0] CH_LC_A  = 8'd97;
   localparam logic [CH_BITS-1:0] CH_LC_Z  = 8'd122;

   // Digit values fit 7 bits; NOT_DIGIT exceeds every legal base
   localparam int DIGIT_BITS = 7;
   localparam logic [DIGIT_BITS-1:0] NOT_DIGIT = 7'd99;
   localparam logic [DIGIT_BITS-1:0] LETTER_BASE = 7'd10;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_INVALID = 2'd2;

   // Parse phase, one-hot
   typedef enum logic [3:0] {
      PH_WS     = 4'b0001,
      PH_SIGN   = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   // Flags from the digit multiply-accumulate unit
   typedef struct packed {
      logic is_digit;
      logic overflow;
   } mac_flags_type;

   // Value of a character as a digit, NOT_DIGIT if it is no digit or letter
   function automatic logic [DIGIT_BITS-1:0] digit_value(input logic [CH_BITS-1:0] ch);
      logic [DIGIT_BITS-1:0] d;
      d = NOT_DIGIT;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         d = DIGIT_BITS'(ch - CH_ZERO);
      end else if (ch >= CH_UC_A && ch <= CH_UC_Z) begin
         d = DIGIT_BITS'(ch - CH_UC_A) + LETTER_BASE;
      end else if (ch >= CH_LC_A && ch <= CH_LC_Z) begin
         d = DIGIT_BITS'(ch - CH_LC_A) + LETTER_BASE;
      end
      return d;
   endfunction

   // Space, tab, LF, VT, FF and CR count as whitespace
   function automatic logic is_space(input logic [CH_BITS-1:0] ch);
      return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
   endfunction

endpackage

// File: rtl/radix_integer_text_parser_top.sv
// Radix integer text parser: character stream in, one parsed integer per string out.
// Depends on ritp_pkg and ritp_digit_mac.
//
// The block takes one character word per clock cycle on the req_ stream and keeps
// the parse state (phase, sign, magnitude, position, overflow) in registers; every
// word is finished in the cycle it is accepted, by one multiply-accumulate of the
// magnitude by the six-bit base plus a limit compare. A word with first set starts a
// new string and drops any unfinished one without a result. After blanks and sign,
// the first non-digit of the base, NUL included, places one result in the output
// register, where it appears on rsp_ the cycle after that character was accepted;
// an illegal base gives an invalid-status result at once. The output register lets
// a new word be accepted while a result drains, so the block sustains one character
// per cycle and stalls only when a result is held and rsp_tready is low. The base
// is set through the CSR port at byte address 0 and must only be changed while idle.
module radix_integer_text_parser_top import ritp_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // Input stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [7:0] ch
   input  logic                     req_tuser,   // [0] first
   // Result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [63:0] value, [79:64] end_index
   output logic [STATUS_BITS-1:0]   rsp_tuser,   // [1:0] status
   // Configuration port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int POS_WIDE = (INDEX_BITS > END_OUT) ? INDEX_BITS : END_OUT;
   localparam logic [INDEX_BITS-1:0] POS_MAX = {INDEX_BITS{1'b1}};

   // Configuration
   logic [RADIX_BITS-1:0] radix_ff;
   logic                  csr_write;

   // Parse state
   phase_type             phase_ff, phase_in;
   logic                  negative_ff, negative_in;
   logic [VALUE_BITS-1:0] magnitude_ff, magnitude_in;
   logic [INDEX_BITS-1:0] position_ff, position_in;
   logic [INDEX_BITS-1:0] pos_digits_ff, pos_digits_in;
   logic                  overflowed_ff, overflowed_in;

   // Result register
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_BITS-1:0]   rsp_user_ff, rsp_user_in;
   logic                     emit;

   // Step signals
   logic                  req_accept;
   logic [CH_BITS-1:0]    ch;
   logic [RADIX_BITS-1:0] base;
   logic                  base_bad;
   logic                  mac_negative;
   logic [VALUE_BITS-1:0] mac_magnitude;
   logic [VALUE_BITS-1:0] mac_next;
   mac_flags_type         mac_flags;

   // CSR write and read-back; only the radix register exists
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = csr_paddr[CSR_ADDR_BITS-1] ? '0 : CSR_DATA_BITS'(radix_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_write && !csr_paddr[CSR_ADDR_BITS-1]) begin
         radix_ff <= csr_pwdata[RADIX_BITS-1:0];
      end
   end

   // Accept a word whenever the result register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign ch         = req_tdata[CH_BITS-1:0];

   // Base check: zero means ten
   assign base     = (radix_ff == '0) ? RADIX_DEFAULT : radix_ff;
   assign base_bad = (base < RADIX_MIN) || (base > RADIX_MAX);

   // A new string sees cleared sign and magnitude
   assign mac_negative  = req_tuser ? 1'b0 : negative_ff;
   assign mac_magnitude = req_tuser ? '0 : magnitude_ff;

   ritp_digit_mac #(
      .VALUE_BITS(VALUE_BITS)
   ) u_digit_mac (
      .ch             (ch),
      .base           (base),
      .magnitude      (mac_magnitude),
      .negative       (mac_negative),
      .magnitude_next (mac_next),
      .flags          (mac_flags)
   );

   // Next parse state and result for the accepted word
   always_comb begin
      phase_type             ph;
      logic                  neg;
      logic [VALUE_BITS-1:0] mag;
      logic [INDEX_BITS-1:0] pos;
      logic [INDEX_BITS-1:0] pos_bumped;
      logic [INDEX_BITS-1:0] pos_dig;
      logic                  ovf;
      logic [VALUE_BITS-1:0] limit;
      logic [VALUE_BITS-1:0] res;
      logic [POS_WIDE-1:0]   end_wide;
      logic                  digit_path;

      ph  = req_tuser ? PH_WS : phase_ff;
      neg = mac_negative;
      mag = mac_magnitude;
      pos = req_tuser ? '0 : position_ff;
      pos_dig = req_tuser ? '0 : pos_digits_ff;
      ovf = req_tuser ? 1'b0 : overflowed_ff;
      pos_bumped = (pos < POS_MAX) ? pos + INDEX_BITS'(1) : pos;
      limit = (VALUE_BITS'(1) << (VALUE_BITS - 1)) - VALUE_BITS'(!neg);
      emit = 1'b0;
      digit_path = 1'b0;
      res = '0;
      rsp_user_in = STATUS_OK;
      end_wide = '0;

      unique case (ph)
         PH_DONE: begin
            // Idle: drop the word
         end
         PH_WS, PH_SIGN, PH_DIGITS: begin
            if (base_bad) begin
               emit = 1'b1;
               rsp_user_in = STATUS_INVALID;
               ph = PH_DONE;
            end else if (ph == PH_WS && is_space(ch)) begin
               pos = pos_bumped;
            end else if (ph == PH_WS && (ch == CH_PLUS || ch == CH_MINUS)) begin
               neg = (ch == CH_MINUS);
               ph  = PH_SIGN;
               pos = pos_bumped;
            end else begin
               digit_path = 1'b1;
            end
         end
         default: begin
            ph = PH_DONE;
         end
      endcase

      if (digit_path) begin
         if (mac_flags.is_digit) begin
            // Accumulate, or latch overflow and keep counting digits
            if (!ovf) begin
               if (mac_flags.overflow) begin
                  ovf = 1'b1;
               end else begin
                  mag = mac_next;
               end
            end
            pos     = pos_bumped;
            pos_dig = pos_bumped;
            ph      = PH_DIGITS;
         end else begin
            // Terminator: report the parsed value
            emit = 1'b1;
            if (ph == PH_DIGITS) begin
               end_wide = POS_WIDE'(pos_dig);
               if (ovf) begin
                  res = neg ? VALUE_BITS'(0) - limit : limit;
                  rsp_user_in = STATUS_RANGE;
               end else begin
                  res = neg ? VALUE_BITS'(0) - mag : mag;
               end
            end
            ph = PH_DONE;
         end
      end

      phase_in      = ph;
      negative_in   = neg;
      magnitude_in  = mag;
      position_in   = pos;
      pos_digits_in = pos_dig;
      overflowed_in = ovf;
      rsp_data_in   = {end_wide[END_OUT-1:0], VALUE_OUT'($signed(res))};
   end

   // Advance the parse state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DONE;
         negative_ff   <= 1'b0;
         magnitude_ff  <= '0;
         position_ff   <= '0;
         pos_digits_ff <= '0;
         overflowed_ff <= 1'b0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         negative_ff   <= negative_in;
         magnitude_ff  <= magnitude_in;
         position_ff   <= position_in;
         pos_digits_ff <= pos_digits_in;
         overflowed_ff <= overflowed_in;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: rtl/ritp_digit_mac.sv
// Digit classification and multiply-accumulate by the base, with overflow check.
// Depends on ritp_pkg.
module ritp_digit_mac import ritp_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic [CH_BITS-1:0]    ch,
   input  logic [RADIX_BITS-1:0] base,
   input  logic [VALUE_BITS-1:0] magnitude,
   input  logic                  negative,
   output logic [VALUE_BITS-1:0] magnitude_next,
   output mac_flags_type         flags
);

   // Product grows by the base width plus the digit carry
   localparam int WIDE_BITS = VALUE_BITS + DIGIT_BITS;

   logic [DIGIT_BITS-1:0] digit;
   logic [WIDE_BITS-1:0]  acc;
   logic [WIDE_BITS-1:0]  limit;

   // Classify the character against the base
   assign digit          = digit_value(ch);
   assign flags.is_digit = digit < {1'b0, base};

   // Accumulate magnitude * base + digit at full width
   assign acc = WIDE_BITS'(magnitude) * WIDE_BITS'(base) + WIDE_BITS'(digit);

   // Limit is 2^(VALUE_BITS-1) for negatives, one less otherwise
   assign limit = (WIDE_BITS'(1) << (VALUE_BITS - 1)) - WIDE_BITS'(!negative);

   assign flags.overflow = acc > limit;
   assign magnitude_next = acc[VALUE_BITS-1:0];

endmodule

// File: rtl/ritp_checker.sv
// Port-level assertions for the radix integer text parser, bound to the top level.
// Depends on ritp_pkg and radix_integer_text_parser_top_defines.svh.
`include "radix_integer_text_parser_top_defines.svh"

module ritp_checker import ritp_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [STATUS_BITS-1:0]   rsp_tuser
);

   // A stalled result word stays offered
   `RITP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp word dropped while stalled")

   // An empty result register never back-pressures the input
   `RITP_ASSERT_NOW(a_req_ready, !rsp_tvalid, req_tready, "req stalled with no result pending")

   // Status is one of the three defined codes
   `RITP_ASSERT_NOW(a_status_code, rsp_tvalid, rsp_tuser <= STATUS_INVALID, "undefined status code")

   // Invalid base reports zero value and zero end index
   `RITP_ASSERT_NOW(a_invalid_zero, rsp_tvalid && rsp_tuser == STATUS_INVALID, rsp_tdata == '0, "invalid base result not zero")

   // Overflow needs at least one digit consumed
   `RITP_ASSERT_NOW(a_range_digits, rsp_tvalid && rsp_tuser == STATUS_RANGE, rsp_tdata[RSP_DATA_BITS-1:VALUE_OUT] != '0, "range result with no digits")

endmodule

bind radix_integer_text_parser_top ritp_checker u_ritp_checker (.*);

// File: tb/tb_radix_integer_text_parser_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for radix_integer_text_parser_top: character words in,
// parsed integers out, checked against an in-bench parse predictor.
// Depends on ritp_pkg and the parser RTL.
module tb_radix_integer_text_parser_top;
   import ritp_pkg::*;

   // Run constants
   localparam logic [CSR_ADDR_BITS-1:0] RADIX_ADDR = '0;
   localparam logic [CH_BITS-1:0]       CH_NUL     = 8'd0;
   localparam logic [CH_BITS-1:0]       CH_SLASH   = 8'd47;
   localparam logic [CH_BITS-1:0]       CH_LETTER_G = 8'd103;
   localparam logic [CH_BITS-1:0]       CH_ALL_ONES = 8'd255;
   localparam int DRAIN_CYCLES = 4;
   localparam int LONG_HOLD    = 400;
   localparam int CHUNKS       = 12;
   localparam int CHUNK_CHARS  = 25;

   typedef struct {
      logic [CH_BITS-1:0] ch;
      bit                 first;
   } char_word_type;

   typedef struct packed {
      logic [VALUE_OUT-1:0]   value;
      logic [END_OUT-1:0]     end_index;
      logic [STATUS_BITS-1:0] status;
   } parse_result_type;

   // DUT ports, all inputs known from time zero
   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // [7:0] ch
   logic                     req_tuser = 1'b0; // [0] first
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // [63:0] value, [79:64] end_index
   logic [STATUS_BITS-1:0]   rsp_tuser;        // [1:0] status
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // Stimulus and checking state
   char_word_type    pending_chars[$];
   parse_result_type expected_parses[$];
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   bit            hold_token = 1'b0;
   bit            seen_token = 1'b0;
   int            hold_left = 0;
   int            chars_sent = 0;
   int            parses_checked = 0;
   int            radix_settings = 0;
   int            fail_count = 0;

   // Predictor copy of the parse state and the base register
   phase_type              pr_phase = PH_DONE;
   bit                     pr_negative = 1'b0;
   logic [63:0]            pr_magnitude = '0;
   logic [END_OUT-1:0]     pr_position = '0;
   logic [END_OUT-1:0]     pr_digits_end = '0;
   bit                     pr_overflow = 1'b0;
   logic [RADIX_BITS-1:0]  pr_radix = RADIX_RESET;

   radix_integer_text_parser_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Weight of a character as a digit; 99 for anything that is no digit or letter
   function automatic int char_weight(input logic [CH_BITS-1:0] c);
      int w;
      w = 99;
      if (c inside {[CH_ZERO:CH_NINE]})      w = int'(c) - int'(CH_ZERO);
      else if (c inside {[CH_UC_A:CH_UC_Z]}) w = int'(c) - int'(CH_UC_A) + 10;
      else if (c inside {[CH_LC_A:CH_LC_Z]}) w = int'(c) - int'(CH_LC_A) + 10;
      return w;
   endfunction

   // Advance the character count, holding at its ceiling
   function automatic void step_position();
      if (pr_position != '1) pr_position = pr_position + 1'b1;
   endfunction

   // Apply one character word to the predictor; returns 1 when it finishes a parse
   function automatic bit parse_char(input logic [CH_BITS-1:0] c, input bit first,
                                     output parse_result_type res);
      int          base;
      int          w;
      logic [71:0] acc;
      logic [63:0] limit;
      res = '0;
      if (first) begin
         pr_phase      = PH_WS;
         pr_negative   = 1'b0;
         pr_magnitude  = '0;
         pr_position   = '0;
         pr_digits_end = '0;
         pr_overflow   = 1'b0;
      end
      if (pr_phase == PH_DONE) return 1'b0;

      base = (pr_radix == 0) ? 10 : int'(pr_radix);
      if (base < 2 || base > 36) begin
         res.status = STATUS_INVALID;
         pr_phase = PH_DONE;
         return 1'b1;
      end

      // Leading blanks and one optional sign
      if (pr_phase == PH_WS) begin
         if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            step_position();
            return 1'b0;
         end
         pr_phase = PH_SIGN;
         if (c == CH_MINUS || c == CH_PLUS) begin
            pr_negative = (c == CH_MINUS);
            step_position();
            return 1'b0;
         end
      end

      limit = 64'h8000_0000_0000_0000 - (pr_negative ? 64'd0 : 64'd1);
      w = char_weight(c);
      if (w < base) begin
         acc = 72'(pr_magnitude) * 72'(base) + 72'(w);
         if (!pr_overflow) begin
            if (acc > 72'(limit)) pr_overflow = 1'b1;
            else pr_magnitude = acc[63:0];
         end
         step_position();
         pr_digits_end = pr_position;
         pr_phase = PH_DIGITS;
         return 1'b0;
      end

      // First non-digit closes the string
      if (pr_phase == PH_DIGITS) begin
         res.end_index = pr_digits_end;
         if (pr_overflow) begin
            res.value  = pr_negative ? (64'd0 - limit) : limit;
            res.status = STATUS_RANGE;
         end else begin
            res.value  = pr_negative ? (64'd0 - pr_magnitude) : pr_magnitude;
            res.status = STATUS_OK;
         end
      end else begin
         res.status = STATUS_OK;
      end
      pr_phase = PH_DONE;
      return 1'b1;
   endfunction

   // Driver: present the head of the queue, predict on acceptance
   always @(posedge clock) begin : char_driver
      parse_result_type res;
      bit               offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (parse_char(pending_chars[0].ch, pending_chars[0].first, res)) begin
               expected_parses.push_back(res);
            end
            void'(pending_chars.pop_front());
            chars_sent++;
         end
         if (!req_tvalid || req_tready) begin
            offer = (pending_chars.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            req_tvalid <= offer;
            if (offer) begin
               req_tdata <= pending_chars[0].ch;
               req_tuser <= pending_chars[0].first;
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold each time the token flips
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         seen_token <= hold_token;
      end else if (seen_token != hold_token) begin
         seen_token <= hold_token;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: compare each result word with the oldest expected parse
   always @(posedge clock) begin : parse_monitor
      parse_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_parses.size() == 0) begin
            $error("unexpected result word: value %0d end_index %0d status %0d",
                   $signed(rsp_tdata[63:0]), rsp_tdata[79:64], rsp_tuser);
            fail_count++;
         end else begin
            exp_res = expected_parses.pop_front();
            parses_checked++;
            if (rsp_tdata[63:0] !== exp_res.value) begin
               $error("value: expected %0d, got %0d",
                      $signed(exp_res.value), $signed(rsp_tdata[63:0]));
               fail_count++;
            end
            if (rsp_tdata[79:64] !== exp_res.end_index) begin
               $error("end_index: expected %0d, got %0d", exp_res.end_index, rsp_tdata[79:64]);
               fail_count++;
            end
            if (rsp_tuser !== exp_res.status) begin
               $error("status: expected %0d, got %0d", exp_res.status, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   task automatic push_word(input logic [CH_BITS-1:0] c, input bit first);
      char_word_type cw;
      cw.ch = c;
      cw.first = first;
      pending_chars.push_back(cw);
   endtask

   task automatic push_text(input string s, input bit starts);
      for (int i = 0; i < s.len(); i++) push_word(s[i], starts && i == 0);
   endtask

   // Hold until every word has gone in and every parse has come out
   task automatic wait_idle();
      while (pending_chars.size() != 0 || req_tvalid || expected_parses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Setup and access cycle; the register takes the value on the access edge
   task automatic write_radix(input logic [RADIX_BITS-1:0] r);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= RADIX_ADDR;
      csr_pwdata  <= CSR_DATA_BITS'(r);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      pr_radix = r;
      radix_settings++;
   endtask

   function automatic logic [CH_BITS-1:0] digit_char(input int v);
      if (v < 10) return CH_ZERO + CH_BITS'(v);
      return ($urandom_range(1) ? CH_UC_A : CH_LC_A) + CH_BITS'(v - 10);
   endfunction

   function automatic logic [CH_BITS-1:0] pick_terminator(input int base);
      logic [CH_BITS-1:0] c;
      do c = CH_BITS'($urandom_range(255)); while (char_weight(c) < base);
      return c;
   endfunction

   // One random string: mostly well-formed, some left open, some noise
   task automatic push_random_string(input int base, output int n);
      logic [CH_BITS-1:0] text[$];
      int kind;
      int r;
      int cnt;
      kind = $urandom_range(99);
      n = 0;
      if (kind < 15) begin
         cnt = $urandom_range(1, 6);
         for (int i = 0; i < cnt; i++)
            push_word(CH_BITS'($urandom_range(255)),
                      $urandom_range(99) < ((i == 0) ? 30 : 5));
         n = cnt;
         return;
      end
      cnt = $urandom_range(0, 3);
      for (int i = 0; i < cnt; i++)
         text.push_back(($urandom_range(5) == 0) ? CH_SPACE
                                                 : CH_BITS'($urandom_range(9, 13)));
      r = $urandom_range(99);
      if (r < 20) text.push_back(CH_MINUS);
      else if (r < 35) text.push_back(CH_PLUS);
      r = $urandom_range(99);
      if (r < 8) cnt = 0;
      else if (r < 18) cnt = $urandom_range(20, 70);
      else cnt = $urandom_range(1, 8);
      for (int i = 0; i < cnt; i++) text.push_back(digit_char($urandom_range(base - 1)));
      if (kind >= 25) text.push_back(pick_terminator(base));
      foreach (text[i]) push_word(text[i], i == 0);
      n = text.size();
      // trailing words that land on a finished parse and are ignored
      if (kind >= 25 && $urandom_range(99) < 15) begin
         cnt = $urandom_range(1, 2);
         for (int i = 0; i < cnt; i++) push_word(CH_BITS'($urandom_range(255)), 1'b0);
      end
   endtask

   initial begin : stimulus
      logic [RADIX_BITS-1:0] chunk_radix[CHUNKS];
      int base;
      int got;
      int total;
      int random_chars;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset base of ten, signs, bounds, blanks, drops, idle words
      push_text("  -123", 1'b1);
      push_word(CH_NUL, 1'b0);
      push_text("+42x", 1'b1);
      push_text("9223372036854775807", 1'b1);
      push_word(CH_NUL, 1'b0);
      push_text("9223372036854775808", 1'b1);
      push_word(CH_NUL, 1'b0);
      push_text("-9223372036854775808", 1'b1);
      push_word(CH_NUL, 1'b0);
      push_text("-92233720368547758090", 1'b1);
      push_word(CH_ALL_ONES, 1'b0);
      push_word(CH_TAB, 1'b1);
      for (int c = int'(CH_TAB) + 1; c <= int'(CH_CR); c++) push_word(CH_BITS'(c), 1'b0);
      push_word(CH_SPACE, 1'b0);
      push_word(CH_MINUS, 1'b0);
      push_word(CH_NUL, 1'b0);
      push_text("123", 1'b1);
      push_text("7", 1'b1);
      push_word(CH_NUL, 1'b0);
      push_word(CH_ALL_ONES, 1'b0);
      push_word(CH_NUL, 1'b0);
      push_word(CH_ZERO + 8'd5, 1'b0);
      push_word(CH_ALL_ONES, 1'b1);
      push_word(CH_NUL, 1'b1);
      wait_idle();

      write_radix(6'd16);
      push_text("DeadBEEF", 1'b1);
      push_word(CH_NUL, 1'b0);
      push_text("-7FFFFFFFFFFFFFFF", 1'b1);
      push_word(CH_LETTER_G, 1'b0);
      push_text("0x1", 1'b1);
      wait_idle();

      write_radix(RADIX_MAX);
      push_text("zZ9", 1'b1);
      push_word(CH_SLASH, 1'b0);
      push_text("ZZZZZZZZZZZZZZ", 1'b1);
      push_word(CH_NUL, 1'b0);
      wait_idle();

      write_radix(RADIX_MIN);
      push_word(CH_MINUS, 1'b1);
      for (int i = 0; i < 64; i++) push_word(CH_ZERO + 8'd1, 1'b0);
      push_word(CH_NUL, 1'b0);
      push_text("1012", 1'b1);
      wait_idle();

      write_radix(6'd0);
      push_text("99z", 1'b1);
      wait_idle();

      // Illegal bases give an invalid result on the first processed word
      write_radix(6'd1);
      push_text("12", 1'b1);
      wait_idle();
      write_radix(6'd37);
      push_text("  5", 1'b1);
      wait_idle();
      write_radix(6'd63);
      push_word(CH_NUL, 1'b1);
      wait_idle();

      // Random part, in chunks of one base each
      chunk_radix = '{6'd10, 6'd36, 6'd2, 6'd16, 6'd0, 6'd8, 6'd10, 6'd63,
                      6'd10, 6'd36, 6'd3, 6'd37};
      chunk_radix[6] = RADIX_BITS'($urandom_range(2, 36));
      chunk_radix[10] = RADIX_BITS'($urandom_range(2, 36));
      random_chars = 0;
      for (int k = 0; k < CHUNKS; k++) begin
         if (k < CHUNKS / 3) begin
            send_idle_pct = 19;
            recv_idle_pct = 65;
         end else if (k < 2 * CHUNKS / 3) begin
            send_idle_pct = 65;
            recv_idle_pct = 19;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_radix(chunk_radix[k]);
         base = (chunk_radix[k] == 0) ? 10 : int'(chunk_radix[k]);
         if (base < 2 || base > 36) base = 10;
         total = 0;
         while (total < CHUNK_CHARS) begin
            push_random_string(base, got);
            total += got;
         end
         // close whatever string is still open
         push_word(CH_NUL, 1'b0);
         random_chars += total;
         // stall the receiver for a long stretch while words keep coming
         if (k == 1 || k == 9) hold_token <= ~hold_token;
         wait_idle();
      end

      wait_idle();
      $display("Run covered %0d character words, %0d parses checked, %0d base writes",
               chars_sent, parses_checked, radix_settings);
      $display("(%0d random words across three idling patterns and long receiver holds)",
               random_chars);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
